[sv/bssm_pkg.sv]
// bssm_pkg: shared types, constants and register codes for the bitplane
// sprite shift and mask block; no dependencies
package bssm_pkg;

  localparam int NPLANES   = 4;
  localparam int MAX_CELLS = 2;
  localparam int WORD_W    = 16;
  localparam int SHIFT_W   = 5;
  localparam int CELLS_W   = 2;
  localparam int COL_W     = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [WORD_W-1:0]  HALF_ONES     = 16'hFFFF;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET   = 5'd16;
  localparam logic [CELLS_W-1:0] CELLS_RESET   = 2'd1;
  localparam logic [CELLS_W-1:0] CELLS_MIN     = 2'd1;
  localparam logic [CELLS_W-1:0] CELLS_MAX     = CELLS_W'(MAX_CELLS);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PLANE0_FILL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE1_FILL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE2_FILL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE3_FILL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_SHIFT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS       = 3'd5;

  typedef logic [NPLANES-1:0][WORD_W-1:0] plane_words_t;

  // one 16-pixel half of a shifted cell: mask and gated pixels per plane
  typedef struct packed {
    logic [WORD_W-1:0] m;
    plane_words_t      pix;
  } half_t;

  localparam half_t ABSENT_HALF = '{m: HALF_ONES, pix: '0};

  // merged column result
  typedef struct packed {
    logic [WORD_W-1:0] and_mask;
    plane_words_t      or_pix;
  } column_t;

endpackage

[sv/bssm_intf.sv]
// bssm_intf: valid/ready channel interfaces for row requests, column
// results and register writes; depends on bssm_pkg
interface bssm_row_if;
  import bssm_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] first_a;
  logic [WORD_W-1:0] first_b;
  logic [WORD_W-1:0] first_c;
  logic [WORD_W-1:0] first_d;
  logic [WORD_W-1:0] second_a;
  logic [WORD_W-1:0] second_b;
  logic [WORD_W-1:0] second_c;
  logic [WORD_W-1:0] second_d;

  modport source (output valid, first_a, first_b, first_c, first_d,
                  second_a, second_b, second_c, second_d, input ready);
  modport sink   (input valid, first_a, first_b, first_c, first_d,
                  second_a, second_b, second_c, second_d, output ready);
endinterface

interface bssm_col_if;
  import bssm_pkg::*;
  logic              valid;
  logic              ready;
  logic [COL_W-1:0]  column_index;
  logic [WORD_W-1:0] and_mask;
  logic [WORD_W-1:0] or_plane0;
  logic [WORD_W-1:0] or_plane1;
  logic [WORD_W-1:0] or_plane2;
  logic [WORD_W-1:0] or_plane3;
  logic              last_column;

  modport source (output valid, column_index, and_mask, or_plane0, or_plane1,
                  or_plane2, or_plane3, last_column, input ready);
  modport sink   (input valid, column_index, and_mask, or_plane0, or_plane1,
                  or_plane2, or_plane3, last_column, output ready);
endinterface

interface bssm_cfg_if;
  import bssm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[sv/bssm_lane.sv]
// bssm_lane: one cell lane; builds the show mask, rotates it and shifts
// and gates the four plane words into two halves; depends on bssm_pkg
module bssm_lane (
  input  bssm_pkg::plane_words_t        words,
  input  bssm_pkg::plane_words_t        fill,
  input  logic [bssm_pkg::SHIFT_W-1:0]  shift,
  output bssm_pkg::half_t               first_half,
  output bssm_pkg::half_t               second_half
);
  import bssm_pkg::*;

  logic [WORD_W-1:0]   mask16;
  logic [2*WORD_W-1:0] seeded;
  logic [2*WORD_W-1:0] rotated;
  logic [SHIFT_W:0]    back_amt;

  // show mask with ones seeded above, rotated left
  assign mask16   = ~(words[0] | words[1] | words[2]) & words[3];
  assign seeded   = {HALF_ONES, mask16};
  assign back_amt = (SHIFT_W+1)'(2*WORD_W) - {1'b0, shift};
  assign rotated  = (seeded << shift) | (seeded >> back_amt);

  // mask halves, then per plane zero-filled shift, fill gate,
  // plane 3 masked by its half
  always_comb begin
    logic [2*WORD_W-1:0] px32;
    first_half.m    = rotated[2*WORD_W-1:WORD_W];
    second_half.m   = rotated[WORD_W-1:0];
    first_half.pix  = '0;
    second_half.pix = '0;
    for (int p = 0; p < NPLANES; p++) begin
      px32 = {{WORD_W{1'b0}}, words[p]} << shift;
      first_half.pix[p]  = px32[2*WORD_W-1:WORD_W] & fill[p];
      second_half.pix[p] = px32[WORD_W-1:0] & fill[p];
      if (p == NPLANES - 1) begin
        first_half.pix[p]  = first_half.pix[p] & ~first_half.m;
        second_half.pix[p] = second_half.pix[p] & ~second_half.m;
      end
    end
  end

endmodule

[sv/bssm_merge.sv]
// bssm_merge: combines the left cell's second half with the right cell's
// first half into one column; depends on bssm_pkg
module bssm_merge (
  input  bssm_pkg::half_t   left_half,
  input  bssm_pkg::half_t   right_half,
  output bssm_pkg::column_t column
);
  import bssm_pkg::*;

  // shared keep mask, left pixels hidden where the right half draws
  always_comb begin
    column.and_mask = left_half.m & right_half.m;
    for (int p = 0; p < NPLANES; p++) begin
      column.or_pix[p] = (left_half.pix[p] & right_half.m) | right_half.pix[p];
    end
  end

endmodule

[sv/bitplane_sprite_shift_mask_top.sv]
// bitplane_sprite_shift_mask_top: register file, cell lanes, row buffer and
// column sequencer; depends on bssm_pkg, bssm_intf, bssm_lane, bssm_merge
// the row is first registered in the row buffer, then each column in the output register
// throughput: one column per cycle while dst is ready; the next row is taken in
//   the cycle its predecessor's last column moves to the output register
// reset: synchronous; fills 0xFFFF, shift 16, one cell, no row in flight
module bitplane_sprite_shift_mask_top (
  input  logic       clk,
  input  logic       rst,
  bssm_row_if.sink   src,
  bssm_col_if.source dst,
  bssm_cfg_if.sink   cfg
);
  import bssm_pkg::*;

  plane_words_t        fill;
  logic [SHIFT_W-1:0]  left_shift;
  logic [CELLS_W-1:0]  cells_per_row;
  logic [CELLS_W-1:0]  cells_eff;

  plane_words_t        cell_words [MAX_CELLS];
  half_t               lane_first [MAX_CELLS];
  half_t               lane_second [MAX_CELLS];
  half_t               row_first [MAX_CELLS];
  half_t               row_second [MAX_CELLS];

  logic                row_valid;
  logic [COL_W-1:0]    col;
  logic [CELLS_W-1:0]  row_cells;
  logic                out_load;
  logic                row_done;
  logic                src_take;
  half_t               left_sel;
  half_t               right_sel;
  column_t             merged;

  // configuration registers, always ready
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill          <= {NPLANES{HALF_ONES}};
      left_shift    <= SHIFT_RESET;
      cells_per_row <= CELLS_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_PLANE0_FILL: fill[0] <= cfg.data[WORD_W-1:0];
        REG_PLANE1_FILL: fill[1] <= cfg.data[WORD_W-1:0];
        REG_PLANE2_FILL: fill[2] <= cfg.data[WORD_W-1:0];
        REG_PLANE3_FILL: fill[3] <= cfg.data[WORD_W-1:0];
        REG_LEFT_SHIFT:  left_shift <= cfg.data[SHIFT_W-1:0];
        REG_CELLS:       cells_per_row <= cfg.data[CELLS_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the cell count to one..max
  always_comb begin
    if (cells_per_row < CELLS_MIN) begin
      cells_eff = CELLS_MIN;
    end else if (cells_per_row > CELLS_MAX) begin
      cells_eff = CELLS_MAX;
    end else begin
      cells_eff = cells_per_row;
    end
  end

  // cell lanes
  assign cell_words[0] = {src.first_d, src.first_c, src.first_b, src.first_a};
  assign cell_words[1] = {src.second_d, src.second_c, src.second_b, src.second_a};

  for (genvar c = 0; c < MAX_CELLS; c++) begin : g_lane
    bssm_lane u_lane (
      .words       (cell_words[c]),
      .fill        (fill),
      .shift       (left_shift),
      .first_half  (lane_first[c]),
      .second_half (lane_second[c])
    );
  end

  // handshake control
  assign out_load  = row_valid && (!dst.valid || dst.ready);
  assign row_done  = out_load && (col == COL_W'(row_cells));
  assign src.ready = !row_valid || row_done;
  assign src_take  = src.valid && src.ready;

  // row buffer holds both halves of every cell
  always_ff @(posedge clk) begin
    if (src_take) begin
      for (int c = 0; c < MAX_CELLS; c++) begin
        row_first[c]  <= lane_first[c];
        row_second[c] <= lane_second[c];
      end
      row_cells <= cells_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= 1'b0;
      col       <= '0;
    end else if (src_take) begin
      row_valid <= 1'b1;
      col       <= '0;
    end else if (row_done) begin
      row_valid <= 1'b0;
    end else if (out_load) begin
      col <= col + COL_W'(1);
    end
  end

  // column source select: absent neighbour at either end
  always_comb begin
    case (col)
      2'd0:    left_sel = ABSENT_HALF;
      2'd1:    left_sel = row_second[0];
      2'd2:    left_sel = row_second[1];
      default: left_sel = ABSENT_HALF;
    endcase
    if (col < COL_W'(row_cells)) begin
      right_sel = row_first[col[0]];
    end else begin
      right_sel = ABSENT_HALF;
    end
  end

  bssm_merge u_merge (
    .left_half  (left_sel),
    .right_half (right_sel),
    .column     (merged)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      dst.valid <= 1'b0;
    end else if (out_load) begin
      dst.valid <= 1'b1;
    end else if (dst.ready) begin
      dst.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      dst.column_index <= col;
      dst.and_mask     <= merged.and_mask;
      dst.or_plane0    <= merged.or_pix[0];
      dst.or_plane1    <= merged.or_pix[1];
      dst.or_plane2    <= merged.or_pix[2];
      dst.or_plane3    <= merged.or_pix[3];
      dst.last_column  <= (col == COL_W'(row_cells));
    end
  end

endmodule
